### hw/rtl/pnt_pkg.sv
// ----------------------------------------------------------------------------
// pnt_pkg
// Shared types, widths and codes for the gradient noise / turbulence block.
// ----------------------------------------------------------------------------
package pnt_pkg;

    localparam int TABLE_SIZE_DEF  = 256;
    localparam int MAX_OCTAVES_DEF = 8;

    // Coordinate fraction width and derived datapath widths
    localparam int COORD_FRAC_BITS = 16;
    localparam int OUT_FRAC        = 16;
    localparam int GRAD_FRAC       = 14;
    localparam int FW      = COORD_FRAC_BITS;
    localparam int SW      = FW + 1;              // smoothstep weight, 0..1.0
    localparam int OW      = FW + 2;              // signed corner offset
    localparam int GW      = 16;                  // gradient component
    localparam int PROD_W  = GW + OW;
    localparam int DSUM_W  = PROD_W + 2;
    localparam int DOT_W   = DSUM_W - GRAD_FRAC;
    localparam int TERM_W  = SW + 1 + DOT_W;
    localparam int ACC_W   = TERM_W + 3;
    localparam int NOISE_W = ACC_W - FW;
    localparam int SUM_W   = NOISE_W + 2;
    localparam int OUT_W   = 24;
    localparam int OUT_SHR = (FW >= OUT_FRAC) ? (FW - OUT_FRAC) : 0;
    localparam int OUT_SHL = (FW >= OUT_FRAC) ? 0 : (OUT_FRAC - FW);
    localparam int CONV_W  = SUM_W + OUT_SHL;

    typedef enum logic [2:0] {
        ACT_LOAD_GRAD = 3'd0,
        ACT_LOAD_PX   = 3'd1,
        ACT_LOAD_PY   = 3'd2,
        ACT_LOAD_PZ   = 3'd3,
        ACT_NOISE     = 3'd4,
        ACT_TURB      = 3'd5
    } pnt_action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SMOOTH1,
        ST_SMOOTH2,
        ST_ISSUE,
        ST_DRAIN,
        ST_OCT_END,
        ST_RESULT
    } pnt_state_t;

    typedef struct packed {
        logic       accept;
        logic       setup;
        logic       smooth1;
        logic       smooth2;
        logic       issue;
        logic [2:0] corner;
        logic       oct_end;
        logic       capture;
    } pnt_cmd_t;

    typedef struct packed {
        logic run_req;
        logic busy;
        logic last_oct;
    } pnt_status_t;

endpackage

### hw/rtl/pnt_ctrl.sv
// ----------------------------------------------------------------------------
// pnt_ctrl
// Sequencer: per octave runs setup, two smoothstep steps, issues the eight
// lattice corners into the datapath pipe, drains it and folds the octave.
// ----------------------------------------------------------------------------
module pnt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pnt_pkg::pnt_status_t status,
    output pnt_pkg::pnt_cmd_t    cmd
);
    import pnt_pkg::*;

    pnt_state_t state_reg, state_next;
    logic [2:0] corner_reg, corner_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            corner_reg    <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = status.run_req ? ST_SETUP : ST_RESULT;
            ST_SETUP:   state_next = ST_SMOOTH1;
            ST_SMOOTH1: state_next = ST_SMOOTH2;
            ST_SMOOTH2: state_next = ST_ISSUE;
            ST_ISSUE:
                if (corner_reg == 3'd7)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!status.busy)
                    state_next = ST_OCT_END;
            ST_OCT_END: state_next = status.last_oct ? ST_RESULT : ST_SETUP;
            ST_RESULT:
                if (out_free)
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        in_ready    = 1'b0;
        corner_next = corner_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SETUP:   cmd.setup   = 1'b1;
            ST_SMOOTH1: cmd.smooth1 = 1'b1;
            ST_SMOOTH2: cmd.smooth2 = 1'b1;
            ST_ISSUE:
            begin
                cmd.issue   = 1'b1;
                corner_next = corner_reg + 3'd1;
            end
            ST_DRAIN:   cmd.corner  = 3'd0;
            ST_OCT_END: cmd.oct_end = 1'b1;
            ST_RESULT:  cmd.capture = out_free;
            default:    cmd         = '0;
        endcase
        cmd.corner = corner_reg;
    end

    // hold the result until taken; a new capture reloads it
    assign out_valid_next = cmd.capture ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign out_valid      = out_valid_reg;

endmodule

### hw/rtl/pnt_datapath.sv
// ----------------------------------------------------------------------------
// pnt_datapath
// Tables, lattice setup, smoothstep weights, five-stage corner pipe
// (perm read, gradient read, products, dot, weighted term) and octave sum.
// ----------------------------------------------------------------------------
module pnt_datapath #(
    parameter int TABLE_SIZE  = pnt_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = pnt_pkg::MAX_OCTAVES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pnt_pkg::pnt_cmd_t                     cmd,
    output pnt_pkg::pnt_status_t                  status,
    input  logic [2:0]                            action,
    input  logic [7:0]                            table_index,
    input  logic signed [15:0]                    grad_x,
    input  logic signed [15:0]                    grad_y,
    input  logic signed [15:0]                    grad_z,
    input  logic [7:0]                            perm_value,
    input  logic signed [31:0]                    point_x,
    input  logic signed [31:0]                    point_y,
    input  logic signed [31:0]                    point_z,
    input  logic [3:0]                            octaves,
    output logic signed [pnt_pkg::OUT_W-1:0]      noise_value,
    output logic                                  load_ack
);
    import pnt_pkg::*;

    localparam int IW  = $clog2(TABLE_SIZE);
    localparam int OCW = $clog2(MAX_OCTAVES + 1);
    localparam logic [SW-1:0]        ONE_S = SW'(1) << FW;
    localparam logic signed [OW-1:0] ONE_O = OW'(1) << FW;
    localparam logic [OW-1:0]        THREE_ONE = OW'(3) << FW;
    localparam logic signed [CONV_W-1:0] OUT_MAX_C = CONV_W'(8388607);
    localparam logic signed [CONV_W-1:0] OUT_MIN_C = -CONV_W'(8388608);

    // tables
    logic [3*GW-1:0] grad_mem [TABLE_SIZE];
    logic [7:0]      perm_x_mem [TABLE_SIZE];
    logic [7:0]      perm_y_mem [TABLE_SIZE];
    logic [7:0]      perm_z_mem [TABLE_SIZE];
    logic [3*GW-1:0] grad_rd_reg;
    logic [7:0]      px_rd_reg, py_rd_reg, pz_rd_reg;

    logic [IW-1:0]   wr_idx, hash, addr_x, addr_y, addr_z;

    // item state
    logic [2:0]              action_reg;
    logic signed [31:0]      pt_reg [3];
    logic [OCW-1:0]          oct_total_reg, oct_cnt_reg, oct_clamp;
    logic signed [SUM_W-1:0] sum_reg;

    // octave state
    logic [IW-1:0]   i_reg [3];
    logic [FW-1:0]   f_reg [3];
    logic [FW-1:0]   t2_reg [3];
    logic [SW-1:0]   s_reg [3];
    logic [31:0]     shifted [3];
    logic [2*FW-1:0] sq [3];
    logic [OW-1:0]   poly [3];
    logic [FW+OW-1:0] sp [3];

    // corner pipe
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [2:0]               k1_reg, k2_reg;
    logic [SW-1:0]            wxy_reg, w_reg, w3_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [DOT_W-1:0]  dot_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [SW-1:0]            wx, wy, wz;
    logic [2*SW-1:0]          wxy_full, w_full;
    logic signed [OW-1:0]     off [3];
    logic signed [GW-1:0]     gcomp [3];
    logic signed [DSUM_W-1:0] dsum;
    logic signed [DSUM_W-1:0] dshift;
    logic signed [SW:0]       w_signed;
    logic signed [ACC_W-1:0]  term_ext;

    logic signed [NOISE_W-1:0] noise, noise_scaled;
    logic signed [SUM_W-1:0]   noise_ext, mag;
    logic signed [CONV_W-1:0]  conv;
    logic signed [OUT_W-1:0]   sat;
    logic                      is_compute, is_load;

    assign wr_idx = IW'(table_index);
    assign oct_clamp = (int'(octaves) > MAX_OCTAVES) ? OCW'(MAX_OCTAVES) : OCW'(octaves);

    assign status.run_req  = (action == ACT_NOISE) || (action == ACT_TURB && octaves != 4'd0);
    assign status.busy     = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;
    assign status.last_oct = (oct_cnt_reg == oct_total_reg - OCW'(1));

    // ---------------- tables ----------------
    assign addr_x = i_reg[0] + IW'(cmd.corner[2]);
    assign addr_y = i_reg[1] + IW'(cmd.corner[1]);
    assign addr_z = i_reg[2] + IW'(cmd.corner[0]);
    assign hash   = IW'(px_rd_reg ^ py_rd_reg ^ pz_rd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept && action == ACT_LOAD_GRAD)
            grad_mem[wr_idx] <= {grad_z, grad_y, grad_x};
        if (cmd.accept && action == ACT_LOAD_PX)
            perm_x_mem[wr_idx] <= perm_value;
        if (cmd.accept && action == ACT_LOAD_PY)
            perm_y_mem[wr_idx] <= perm_value;
        if (cmd.accept && action == ACT_LOAD_PZ)
            perm_z_mem[wr_idx] <= perm_value;
        px_rd_reg   <= perm_x_mem[addr_x];
        py_rd_reg   <= perm_y_mem[addr_y];
        pz_rd_reg   <= perm_z_mem[addr_z];
        grad_rd_reg <= grad_mem[hash];
    end

    // ---------------- octave setup and smoothstep ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shifted[i] = pt_reg[i] << oct_cnt_reg;
            sq[i]      = f_reg[i] * f_reg[i];
            poly[i]    = THREE_ONE - {1'b0, f_reg[i], 1'b0};
            sp[i]      = t2_reg[i] * poly[i];
        end
    end

    // ---------------- corner pipe arithmetic ----------------
    always_comb
    begin
        wx       = k1_reg[2] ? s_reg[0] : ONE_S - s_reg[0];
        wy       = k1_reg[1] ? s_reg[1] : ONE_S - s_reg[1];
        wz       = k2_reg[0] ? s_reg[2] : ONE_S - s_reg[2];
        wxy_full = wx * wy;
        w_full   = wxy_reg * wz;
        for (int i = 0; i < 3; i++)
        begin
            off[i]   = $signed({2'b00, f_reg[i]}) - (k2_reg[2-i] ? ONE_O : '0);
            gcomp[i] = $signed(grad_rd_reg[GW*i +: GW]);
        end
        dsum     = DSUM_W'(prod_reg[0]) + DSUM_W'(prod_reg[1]) + DSUM_W'(prod_reg[2]);
        dshift   = dsum >>> GRAD_FRAC;
        w_signed = $signed({1'b0, w3_reg});
        term_ext = term_reg;
    end

    // ---------------- octave fold and result ----------------
    always_comb
    begin
        noise        = NOISE_W'(acc_reg >>> FW);
        noise_scaled = noise >>> oct_cnt_reg;
        noise_ext    = noise_scaled;
        is_compute   = (action_reg == ACT_NOISE) || (action_reg == ACT_TURB);
        is_load      = (action_reg == ACT_LOAD_GRAD) || (action_reg == ACT_LOAD_PX)
                    || (action_reg == ACT_LOAD_PY) || (action_reg == ACT_LOAD_PZ);
        mag          = (action_reg == ACT_TURB && sum_reg < 0) ? -sum_reg : sum_reg;
        conv         = CONV_W'(mag >>> OUT_SHR) <<< OUT_SHL;
        if (conv > OUT_MAX_C)
            sat = OUT_W'(OUT_MAX_C);
        else if (conv < OUT_MIN_C)
            sat = OUT_W'(OUT_MIN_C);
        else
            sat = OUT_W'(conv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg    <= action;
            pt_reg[0]     <= point_x;
            pt_reg[1]     <= point_y;
            pt_reg[2]     <= point_z;
            oct_total_reg <= (action == ACT_NOISE) ? OCW'(1) : oct_clamp;
            oct_cnt_reg   <= '0;
            sum_reg       <= '0;
        end
        if (cmd.setup)
        begin
            for (int i = 0; i < 3; i++)
            begin
                i_reg[i] <= shifted[i][FW +: IW];
                f_reg[i] <= shifted[i][FW-1:0];
            end
        end
        if (cmd.smooth1)
            for (int i = 0; i < 3; i++)
                t2_reg[i] <= sq[i][2*FW-1:FW];
        if (cmd.smooth2)
            for (int i = 0; i < 3; i++)
                s_reg[i] <= SW'(sp[i] >> FW);

        k1_reg  <= cmd.corner;
        k2_reg  <= k1_reg;
        wxy_reg <= SW'(wxy_full >> FW);
        for (int i = 0; i < 3; i++)
            prod_reg[i] <= gcomp[i] * off[i];
        w_reg    <= SW'(w_full >> FW);
        dot_reg  <= DOT_W'(dshift);
        w3_reg   <= w_reg;
        term_reg <= w_signed * dot_reg;

        if (cmd.setup)
            acc_reg <= '0;
        else if (v5_reg)
            acc_reg <= acc_reg + term_ext;

        if (cmd.oct_end)
        begin
            sum_reg     <= sum_reg + noise_ext;
            oct_cnt_reg <= oct_cnt_reg + OCW'(1);
        end

        if (cmd.capture)
        begin
            noise_value <= is_compute ? sat : '0;
            load_ack    <= is_load;
        end
    end

endmodule

### hw/rtl/perlin_noise_turbulence.sv
// ----------------------------------------------------------------------------
// perlin_noise_turbulence
// 3D gradient noise and turbulence, Q16.16 in, saturated Q8.16 out.
//
//   channel | signals                                     | handshake
//   input   | action table_index grad_x/y/z perm_value    | in_valid / in_ready
//           | point_x/y/z octaves                         |
//   output  | noise_value load_ack                        | out_valid / out_ready
//
// Loads, unused actions and zero-octave turbulence go from accept straight to
// the result step. Otherwise the item runs N octaves (one for noise); each
// octave is setup, two smoothstep steps, eight corners issued one per cycle
// through the shared table/multiply pipe, a drain of that pipe and the fold.
// The next item can be accepted in the cycle its result appears. Reset
// clears control only; tables are undefined until loaded. A waiting result
// holds; the next item is accepted meanwhile and its result waits in the
// last step until the output register frees.
// ----------------------------------------------------------------------------
module perlin_noise_turbulence #(
    parameter int TABLE_SIZE  = pnt_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = pnt_pkg::MAX_OCTAVES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       action,
    input  logic [7:0]                       table_index,
    input  logic signed [15:0]               grad_x,
    input  logic signed [15:0]               grad_y,
    input  logic signed [15:0]               grad_z,
    input  logic [7:0]                       perm_value,
    input  logic signed [31:0]               point_x,
    input  logic signed [31:0]               point_y,
    input  logic signed [31:0]               point_z,
    input  logic [3:0]                       octaves,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [pnt_pkg::OUT_W-1:0] noise_value,
    output logic                             load_ack
);
    import pnt_pkg::*;

    pnt_cmd_t    cmd;
    pnt_status_t status;

    pnt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pnt_datapath #(
        .TABLE_SIZE  (TABLE_SIZE),
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .action      (action),
        .table_index (table_index),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z),
        .perm_value  (perm_value),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .octaves     (octaves),
        .noise_value (noise_value),
        .load_ack    (load_ack)
    );

endmodule
